// File: sv/urtrb_pkg.sv
package urtrb_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    CMD_RECEIVE  = 3'd0,
    CMD_READ     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_TX_READY = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RX_OVERFLOW = 2'd1,
    ST_TX_FULL     = 2'd2,
    ST_RX_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic nonempty_next;
  } ring_sts_t;

  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// File: sv/urtrb_ram.sv
module urtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/urtrb_ring.sv
module urtrb_ring (
  input  logic                  clk,
  input  logic                  rst,
  input  urtrb_pkg::ring_ctl_t  ctl,
  input  logic [7:0]            wdata,
  output urtrb_pkg::ring_sts_t  sts,
  output logic [7:0]            rdata
);
  import urtrb_pkg::*;

  ptr_t head;
  ptr_t tail;
  ptr_t head_next;
  ptr_t tail_next;
  ptr_t head_inc;
  ptr_t tail_inc;

  // pointers advance first, then the new slot is used
  assign head_inc = ring_next(head);
  assign tail_inc = ring_next(tail);

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (ctl.clear) begin
      head_next = '0;
      tail_next = '0;
    end else begin
      if (ctl.push) head_next = head_inc;
      if (ctl.pop) tail_next = tail_inc;
    end
  end

  assign sts.empty         = (head == tail);
  assign sts.full          = (head_inc == tail);
  assign sts.nonempty_next = (head_next != tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  urtrb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (head_inc),
    .wdata (wdata),
    .re    (ctl.pop),
    .raddr (tail_inc),
    .rdata (rdata)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !sts.full)
    else $error("push into full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !sts.empty)
    else $error("pop from empty ring");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> sts.empty)
    else $error("ring not empty after clear");

endmodule

// File: sv/uart_rx_tx_ring_buffers.sv
// Receive and transmit byte rings between a serial port and a host. Each
// command on the input stream gives exactly one result on the output stream.
// A command is taken every cycle while results are drained; a result is
// registered in the read stage and then the output stage, since each ring's
// bytes live in a 64 x 8 RAM with a registered read. When the output waits,
// one more command is held in the read stage and the input then stalls.
// Each ring holds DEPTH-1 bytes; there is no clearing pass after reset.
module uart_rx_tx_ring_buffers (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] command, [10:3] data_in
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] data_out, [8] data_valid, [10:9] status, [11] rx_available,
  // [12] tx_irq_enable
  output logic [15:0] m_tdata
);
  import urtrb_pkg::*;

  logic       acc;
  logic [7:0] din;
  ring_ctl_t  rx_ctl;
  ring_ctl_t  tx_ctl;
  ring_sts_t  rx_sts;
  ring_sts_t  tx_sts;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  logic       irq;
  logic       irq_next;
  status_t    st;
  logic       dv;
  logic       sel_tx;

  // read stage: waits for the ram data
  logic       p_valid;
  logic       p_dv;
  logic       p_sel_tx;
  status_t    p_status;
  logic       p_rxav;
  logic       p_irq;
  logic       move;
  logic [7:0] dout;

  logic       o_valid;
  logic [15:0] o_data;

  assign acc = s_tvalid && s_tready;
  assign din = s_tdata[10:3];

  always_comb begin
    rx_ctl   = '0;
    tx_ctl   = '0;
    st       = ST_OK;
    dv       = 1'b0;
    sel_tx   = 1'b0;
    irq_next = irq;
    unique case (s_tdata[2:0])
      CMD_RECEIVE: begin
        if (rx_sts.full) st = ST_RX_OVERFLOW;
        else rx_ctl.push = acc;
      end
      CMD_READ: begin
        if (rx_sts.empty) begin
          st = ST_RX_EMPTY;
        end else begin
          rx_ctl.pop = acc;
          dv = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (tx_sts.full) begin
          st = ST_TX_FULL;
        end else begin
          tx_ctl.push = acc;
          irq_next = 1'b1;
        end
      end
      CMD_TX_READY: begin
        if (tx_sts.empty) begin
          irq_next = 1'b0;
        end else begin
          tx_ctl.pop = acc;
          dv = 1'b1;
          sel_tx = 1'b1;
        end
      end
      CMD_CLEAR: begin
        rx_ctl.clear = acc;
        tx_ctl.clear = acc;
      end
      default: begin
      end
    endcase
  end

  urtrb_ring u_rx (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (din),
    .sts   (rx_sts),
    .rdata (rx_rdata)
  );

  urtrb_ring u_tx (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (din),
    .sts   (tx_sts),
    .rdata (tx_rdata)
  );

  assign move     = p_valid && (!o_valid || m_tready);
  assign s_tready = !p_valid || move;
  assign dout     = !p_dv ? 8'd0 : (p_sel_tx ? tx_rdata : rx_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      irq     <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (acc) irq <= irq_next;
      if (acc) p_valid <= 1'b1;
      else if (move) p_valid <= 1'b0;
      if (move) o_valid <= 1'b1;
      else if (m_tready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_dv     <= dv;
      p_sel_tx <= sel_tx;
      p_status <= st;
      p_rxav   <= rx_sts.nonempty_next;
      p_irq    <= irq_next;
    end
    if (move) begin
      o_data <= {3'b000, p_irq, p_rxav, p_status, p_dv, dout};
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("data_out not zero without data_valid");

  a_irq_set_on_write: assert property (@(posedge clk) disable iff (rst)
    tx_ctl.push |=> irq)
    else $error("transmit interrupt enable not set after write");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import urtrb_pkg::*;

  localparam int WATCHDOG_CYCLES  = 5000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 16;
  localparam int MAX_REPORTS      = 10;

  // command codes that the block must ignore
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  // one result transaction, lowest field last
  typedef struct packed {
    logic       tx_irq;
    logic       rx_avail;
    status_t    status;
    logic       valid;
    logic [7:0] data;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  // predicted ring state
  logic [7:0] rx_mem [DEPTH];
  logic [7:0] tx_mem [DEPTH];
  ptr_t       rx_head = '0;
  ptr_t       rx_tail = '0;
  ptr_t       tx_head = '0;
  ptr_t       tx_tail = '0;
  logic       tx_irq  = 1'b0;

  ring_result_t ring_result_q [$];
  int           error_count  = 0;
  int           stall_cycles = 0;
  bit           no_idle      = 1'b0;
  bit           hold_sink    = 1'b0;

  uart_rx_tx_ring_buffers u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic ptr_t ptr_advance(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // updates the predicted rings and returns the result of one command
  function automatic ring_result_t apply_ring_command(logic [2:0] cmd, logic [7:0] din);
    ring_result_t r;
    ptr_t         nxt;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_RECEIVE: begin
        nxt = ptr_advance(rx_head);
        if (nxt == rx_tail) begin
          r.status = ST_RX_OVERFLOW;
        end else begin
          rx_head = nxt;
          rx_mem[nxt] = din;
        end
      end
      CMD_READ: begin
        if (rx_head == rx_tail) begin
          r.status = ST_RX_EMPTY;
        end else begin
          rx_tail = ptr_advance(rx_tail);
          r.data  = rx_mem[rx_tail];
          r.valid = 1'b1;
        end
      end
      CMD_WRITE: begin
        nxt = ptr_advance(tx_head);
        if (nxt == tx_tail) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_mem[nxt] = din;
          tx_head = nxt;
          tx_irq  = 1'b1;
        end
      end
      CMD_TX_READY: begin
        if (tx_head != tx_tail) begin
          tx_tail = ptr_advance(tx_tail);
          r.data  = tx_mem[tx_tail];
          r.valid = 1'b1;
        end else begin
          tx_irq = 1'b0;
        end
      end
      CMD_CLEAR: begin
        rx_head = '0;
        rx_tail = '0;
        tx_head = '0;
        tx_tail = '0;
      end
      default: begin
      end
    endcase
    r.rx_avail = (rx_head != rx_tail);
    r.tx_irq   = tx_irq;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // rx_bias and tx_bias: percent of producer commands on each ring
  function automatic logic [2:0] pick_cmd(int rx_bias, int tx_bias);
    int r;
    r = $urandom_range(0, 999);
    if (r < 5) return CMD_CLEAR;
    if (r < 35) return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if (r < 500) return ($urandom_range(0, 99) < rx_bias) ? CMD_RECEIVE : CMD_READ;
    return ($urandom_range(0, 99) < tx_bias) ? CMD_WRITE : CMD_TX_READY;
  endfunction

  // valid is left high on return so the next command can follow at once
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] din);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, din, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ring_result_q.push_back(apply_ring_command(cmd, din));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (ring_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string what, input ring_result_t exp,
                              input ring_result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s: expected data=%02h valid=%0b status=%0d rx_avail=%0b irq=%0b",
               what, exp.data, exp.valid, exp.status, exp.rx_avail, exp.tx_irq);
      $display("  actual data=%02h valid=%0b status=%0d rx_avail=%0b irq=%0b",
               got.data, got.valid, got.status, got.rx_avail, got.tx_irq);
    end
  endtask

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(ring_result_t)-1:0];
      if (ring_result_q.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        exp = ring_result_q.pop_front();
        if (got.data !== exp.data || got.valid !== exp.valid ||
            got.status !== exp.status || got.rx_avail !== exp.rx_avail ||
            got.tx_irq !== exp.tx_irq) begin
          note_failure("result mismatch", exp, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic test_directed();
    send_cmd(CMD_TX_READY, 8'h00);    // transmitter ready on empty ring
    send_cmd(CMD_READ, 8'hff);        // read of empty receive ring
    send_cmd(CMD_RECEIVE, 8'h00);
    send_cmd(CMD_RECEIVE, 8'hff);
    send_cmd(CMD_READ, 8'h00);
    send_cmd(CMD_READ, 8'h00);
    send_cmd(CMD_WRITE, 8'ha5);       // sets the interrupt enable
    send_cmd(CMD_WRITE, 8'h5a);
    send_cmd(CMD_TX_READY, 8'hff);
    send_cmd(CMD_TX_READY, 8'h00);
    send_cmd(CMD_TX_READY, 8'h00);    // ring drained, enable drops
    send_cmd(CMD_RECEIVE, 8'h3c);
    send_cmd(CMD_WRITE, 8'hc3);
    send_cmd(CMD_CLEAR, 8'hff);       // pointers reset, enable kept
    send_cmd(CMD_UNUSED_LO, 8'hff);
    send_cmd(CMD_UNUSED_MID, 8'h80);
    send_cmd(CMD_UNUSED_HI, 8'h01);
    send_cmd(CMD_READ, 8'h00);
    send_cmd(CMD_TX_READY, 8'h00);
    send_cmd(CMD_WRITE, 8'h80);
    send_cmd(CMD_TX_READY, 8'hff);
  endtask

  // fill both rings past full, then drain both past empty
  task automatic test_ring_limits();
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd(CMD_RECEIVE, 8'($urandom_range(0, 255)));
      send_cmd(CMD_WRITE, 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd(CMD_READ, 8'($urandom_range(0, 255)));
      send_cmd(CMD_TX_READY, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int rx_bias;
    int tx_bias;
    for (int phase = 0; phase < 6; phase++) begin
      rx_bias = $urandom_range(1, 9) * 10;
      tx_bias = $urandom_range(1, 9) * 10;
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (160) send_cmd(pick_cmd(rx_bias, tx_bias), 8'($urandom_range(0, 255)));
    end
    no_idle = 1'b0;
  endtask

  // output held off while commands keep coming, so the input stalls
  task automatic test_output_stall();
    hold_sink = 1'b1;
    no_idle   = 1'b1;
    repeat (60) send_cmd(pick_cmd(60, 60), 8'($urandom_range(0, 255)));
    no_idle   = 1'b0;
  endtask

  task automatic test_drain_pauses();
    repeat (3) begin
      repeat (15) send_cmd(pick_cmd(50, 50), 8'($urandom_range(0, 255)));
      wait_results_drained();
    end
  endtask

  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    rst      <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_ring_limits();
    test_random_traffic();
    test_output_stall();
    test_drain_pauses();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
